// ===== hw/rtl/fps_pkg.sv =====
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the flight phase sequencer: phase and command
// codes, register indexes, timing constants and configuration reset values.
// ----------------------------------------------------------------------------
package fps_pkg;

    typedef enum logic [3:0] {
        PH_INIT      = 4'd0,
        PH_CALIB     = 4'd1,
        PH_FILL      = 4'd2,
        PH_ARMED     = 4'd3,
        PH_PRESS     = 4'd4,
        PH_IGNITION  = 4'd5,
        PH_BURN      = 4'd6,
        PH_ASCENT    = 4'd7,
        PH_DESCENT   = 4'd8,
        PH_LANDED    = 4'd9,
        PH_ABORT_GND = 4'd10,
        PH_ABORT_FLT = 4'd11
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE       = 3'd0,
        CMD_CALIBRATE  = 3'd1,
        CMD_ABORT      = 3'd2,
        CMD_ARM        = 3'd3,
        CMD_PRESSURIZE = 3'd4,
        CMD_RECOVER    = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        REG_CRITICAL_PRESSURE  = 3'd0,
        REG_OX_LOW_PRESSURE    = 3'd1,
        REG_OX_HIGH_PRESSURE   = 3'd2,
        REG_FUEL_LOW_PRESSURE  = 3'd3,
        REG_FUEL_HIGH_PRESSURE = 3'd4,
        REG_HOLD_DELAY_MS      = 3'd5,
        REG_BURN_LIMIT_MS      = 3'd6,
        REG_ASCENT_LIMIT_MS    = 3'd7
    } reg_idx_t;

    localparam int unsigned ADDR_W = 5;

    localparam logic [31:0] DESCENT_MIN_MS        = 32'd5000;
    localparam logic [31:0] DEPRESSURIZE_DELAY_MS = 32'd50000;

    localparam logic [15:0] CRITICAL_PRESSURE_RST  = 16'd65535;
    localparam logic [15:0] OX_LOW_PRESSURE_RST    = 16'd0;
    localparam logic [15:0] OX_HIGH_PRESSURE_RST   = 16'd65535;
    localparam logic [15:0] FUEL_LOW_PRESSURE_RST  = 16'd0;
    localparam logic [15:0] FUEL_HIGH_PRESSURE_RST = 16'd65535;
    localparam logic [31:0] HOLD_DELAY_MS_RST      = 32'd10000;
    localparam logic [31:0] BURN_LIMIT_MS_RST      = 32'd120000;
    localparam logic [31:0] ASCENT_LIMIT_MS_RST    = 32'd60000;

endpackage

// ===== hw/rtl/flight_phase_sequencer_unit.sv =====
// An accepted item waits in the input register and moves on to the result
// register when that register is empty or its result is being taken.
// Throughput: one item per cycle while out_stall is low; the phase update is a single pass of
// compares and 32-bit subtractions between the two registers.
// Reset: phase returns to init, timestamps, elapsed times and flags clear,
// configuration registers take their default values.
// ----------------------------------------------------------------------------
// flight_phase_sequencer_unit
// Twelve-phase vehicle sequencer with liftoff override, phase entry
// timestamps, elapsed times and one-shot action pulses. APB register port.
// ----------------------------------------------------------------------------
module flight_phase_sequencer_unit
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [fps_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [31:0]               now_ms,
    input  logic [2:0]                command,
    input  logic                      calibrated,
    input  logic                      fatal_fault,
    input  logic                      cutoff_seen,
    input  logic                      apogee_seen,
    input  logic                      touchdown_seen,
    input  logic                      imu_liftoff,
    input  logic                      force_liftoff,
    input  logic [15:0]               fuel_pressure,
    input  logic [15:0]               ox_pressure,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [3:0]                phase,
    output logic                      phase_changed,
    output logic                      ignite_pulse,
    output logic                      abort_pulse,
    output logic                      pressurize_off_pulse,
    output logic                      engine_passivate_pulse,
    output logic                      tank_passivate_pulse,
    output logic                      liftoff_pulse,
    output logic                      lifted_off,
    output logic [31:0]               flight_time_ms
);
    import fps_pkg::*;

    // configuration
    logic [15:0] critical_pressure_reg;
    logic [15:0] ox_low_pressure_reg;
    logic [15:0] ox_high_pressure_reg;
    logic [15:0] fuel_low_pressure_reg;
    logic [15:0] fuel_high_pressure_reg;
    logic [31:0] hold_delay_ms_reg;
    logic [31:0] burn_limit_ms_reg;
    logic [31:0] ascent_limit_ms_reg;

    // input stage
    logic        in_valid_reg;
    logic [31:0] now_reg;
    logic [2:0]  cmd_reg;
    logic        calibrated_reg;
    logic        cata_reg;
    logic        cutoff_reg;
    logic        apogee_reg;
    logic        touchdown_reg;
    logic        imu_reg;
    logic        force_reg;
    logic [15:0] fuel_reg;
    logic [15:0] ox_reg;

    // sequencer state
    phase_t      phase_reg;
    logic [31:0] press_entry_reg;
    logic [31:0] liftoff_time_reg;
    logic [31:0] ascent_entry_reg;
    logic [31:0] descent_entry_reg;
    logic        liftoff_flag_reg;
    logic        tank_done_reg;
    logic [31:0] burn_elapsed_reg;
    logic [31:0] ascent_elapsed_reg;
    logic [31:0] descent_elapsed_reg;

    // result stage
    logic        out_valid_reg;
    logic [3:0]  res_phase_reg;
    logic        res_changed_reg;
    logic        res_ignite_reg;
    logic        res_abort_reg;
    logic        res_poff_reg;
    logic        res_epass_reg;
    logic        res_tpass_reg;
    logic        res_lift_reg;
    logic        res_lifted_reg;
    logic [31:0] res_ftime_reg;

    logic        advance;
    logic        accept;
    logic        cfg_write;
    reg_idx_t    cfg_idx;

    phase_t      normal_next;
    phase_t      phase_next;
    logic        changed;
    logic        abort_cmd;
    logic        held;
    logic        nominal;
    logic        enter_press;
    logic        enter_burn;
    logic        enter_ascent;
    logic        enter_descent;
    logic [31:0] press_entry_next;
    logic [31:0] liftoff_time_next;
    logic [31:0] ascent_entry_next;
    logic [31:0] descent_entry_next;
    logic        liftoff_flag_next;
    logic        tank_done_eff;
    logic        tank_done_next;
    logic        tpass;
    logic [31:0] descent_since;
    logic [31:0] burn_elapsed_next;
    logic [31:0] ascent_elapsed_next;
    logic [31:0] descent_elapsed_next;
    logic [31:0] ftime;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        case (cfg_idx)
            REG_CRITICAL_PRESSURE:  prdata = {16'd0, critical_pressure_reg};
            REG_OX_LOW_PRESSURE:    prdata = {16'd0, ox_low_pressure_reg};
            REG_OX_HIGH_PRESSURE:   prdata = {16'd0, ox_high_pressure_reg};
            REG_FUEL_LOW_PRESSURE:  prdata = {16'd0, fuel_low_pressure_reg};
            REG_FUEL_HIGH_PRESSURE: prdata = {16'd0, fuel_high_pressure_reg};
            REG_HOLD_DELAY_MS:      prdata = hold_delay_ms_reg;
            REG_BURN_LIMIT_MS:      prdata = burn_limit_ms_reg;
            REG_ASCENT_LIMIT_MS:    prdata = ascent_limit_ms_reg;
            default:                prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_pressure_reg  <= CRITICAL_PRESSURE_RST;
            ox_low_pressure_reg    <= OX_LOW_PRESSURE_RST;
            ox_high_pressure_reg   <= OX_HIGH_PRESSURE_RST;
            fuel_low_pressure_reg  <= FUEL_LOW_PRESSURE_RST;
            fuel_high_pressure_reg <= FUEL_HIGH_PRESSURE_RST;
            hold_delay_ms_reg      <= HOLD_DELAY_MS_RST;
            burn_limit_ms_reg      <= BURN_LIMIT_MS_RST;
            ascent_limit_ms_reg    <= ASCENT_LIMIT_MS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_CRITICAL_PRESSURE:  critical_pressure_reg  <= pwdata[15:0];
                REG_OX_LOW_PRESSURE:    ox_low_pressure_reg    <= pwdata[15:0];
                REG_OX_HIGH_PRESSURE:   ox_high_pressure_reg   <= pwdata[15:0];
                REG_FUEL_LOW_PRESSURE:  fuel_low_pressure_reg  <= pwdata[15:0];
                REG_FUEL_HIGH_PRESSURE: fuel_high_pressure_reg <= pwdata[15:0];
                REG_HOLD_DELAY_MS:      hold_delay_ms_reg      <= pwdata;
                REG_BURN_LIMIT_MS:      burn_limit_ms_reg      <= pwdata;
                REG_ASCENT_LIMIT_MS:    ascent_limit_ms_reg    <= pwdata;
                default:                ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: move an item on when the result register is free
    // ------------------------------------------------------------------
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            now_reg        <= now_ms;
            cmd_reg        <= command;
            calibrated_reg <= calibrated;
            cata_reg       <= fatal_fault;
            cutoff_reg     <= cutoff_seen;
            apogee_reg     <= apogee_seen;
            touchdown_reg  <= touchdown_seen;
            imu_reg        <= imu_liftoff;
            force_reg      <= force_liftoff;
            fuel_reg       <= fuel_pressure;
            ox_reg         <= ox_pressure;
        end
    end

    // ------------------------------------------------------------------
    // phase transition
    // ------------------------------------------------------------------
    assign abort_cmd = (cmd_reg == CMD_ABORT);
    assign held      = (now_reg - press_entry_reg) >= hold_delay_ms_reg;
    assign nominal   = (ox_reg < ox_high_pressure_reg) && (fuel_reg < fuel_high_pressure_reg)
                    && (ox_reg > ox_low_pressure_reg) && (fuel_reg > fuel_low_pressure_reg);

    always_comb
    begin
        case (phase_reg)
            PH_INIT:
                normal_next = (cmd_reg == CMD_CALIBRATE) ? PH_FILL : PH_INIT;
            PH_CALIB:
                normal_next = abort_cmd ? PH_ABORT_GND : (calibrated_reg ? PH_FILL : PH_CALIB);
            PH_FILL:
                normal_next = abort_cmd ? PH_ABORT_GND
                            : ((cmd_reg == CMD_ARM) ? PH_ARMED : PH_FILL);
            PH_ARMED:
                normal_next = abort_cmd ? PH_ABORT_GND
                            : ((cmd_reg == CMD_PRESSURIZE) ? PH_PRESS : PH_ARMED);
            PH_PRESS:
            begin
                if (abort_cmd || fuel_reg > critical_pressure_reg
                    || ox_reg > critical_pressure_reg)
                    normal_next = PH_ABORT_GND;
                else
                    normal_next = (held && nominal) ? PH_IGNITION : PH_PRESS;
            end
            PH_IGNITION:
                normal_next = (cata_reg || abort_cmd) ? PH_ABORT_GND : PH_BURN;
            PH_BURN:
            begin
                if (cata_reg || abort_cmd)
                    normal_next = PH_ABORT_FLT;
                else
                    normal_next = (cutoff_reg || burn_elapsed_reg > burn_limit_ms_reg)
                                ? PH_ASCENT : PH_BURN;
            end
            PH_ASCENT:
            begin
                if (cata_reg || abort_cmd)
                    normal_next = PH_ABORT_FLT;
                else
                    normal_next = (apogee_reg || ascent_elapsed_reg > ascent_limit_ms_reg)
                                ? PH_DESCENT : PH_ASCENT;
            end
            PH_DESCENT:
            begin
                if (cata_reg || abort_cmd)
                    normal_next = PH_ABORT_FLT;
                else
                    normal_next = (touchdown_reg && descent_elapsed_reg > DESCENT_MIN_MS)
                                ? PH_LANDED : PH_DESCENT;
            end
            PH_LANDED:
                normal_next = abort_cmd ? PH_ABORT_GND : PH_LANDED;
            PH_ABORT_GND:
                normal_next = (cmd_reg == CMD_RECOVER) ? PH_INIT : PH_ABORT_GND;
            PH_ABORT_FLT:
                normal_next = (cmd_reg == CMD_RECOVER) ? PH_INIT : PH_ABORT_FLT;
            default:
                normal_next = PH_ABORT_GND;
        endcase
    end

    // liftoff override wins over any pre-flight transition
    always_comb
    begin
        if ((force_reg || imu_reg) && (phase_reg <= PH_IGNITION))
            phase_next = PH_BURN;
        else
            phase_next = normal_next;
    end

    assign changed       = (phase_next != phase_reg);
    assign enter_press   = changed && (phase_next == PH_PRESS);
    assign enter_burn    = changed && (phase_next == PH_BURN);
    assign enter_ascent  = changed && (phase_next == PH_ASCENT);
    assign enter_descent = changed && (phase_next == PH_DESCENT);

    assign press_entry_next   = enter_press   ? now_reg : press_entry_reg;
    assign liftoff_time_next  = enter_burn    ? now_reg : liftoff_time_reg;
    assign ascent_entry_next  = enter_ascent  ? now_reg : ascent_entry_reg;
    assign descent_entry_next = enter_descent ? now_reg : descent_entry_reg;
    assign liftoff_flag_next  = liftoff_flag_reg || enter_burn;

    // re-arm tank passivation on each descent entry
    assign tank_done_eff  = tank_done_reg && !enter_descent;
    assign descent_since  = now_reg - descent_entry_next;
    assign tpass          = (phase_next == PH_DESCENT) && !tank_done_eff
                         && (descent_since >= DEPRESSURIZE_DELAY_MS);
    assign tank_done_next = tank_done_eff || tpass;

    assign burn_elapsed_next    = (phase_next == PH_BURN) ? (now_reg - liftoff_time_next)
                                : burn_elapsed_reg;
    assign ascent_elapsed_next  = (phase_next == PH_ASCENT) ? (now_reg - ascent_entry_next)
                                : ascent_elapsed_reg;
    assign descent_elapsed_next = (phase_next == PH_DESCENT) ? descent_since
                                : descent_elapsed_reg;
    assign ftime = liftoff_flag_next ? (now_reg - liftoff_time_next) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg           <= PH_INIT;
            press_entry_reg     <= 32'd0;
            liftoff_time_reg    <= 32'd0;
            ascent_entry_reg    <= 32'd0;
            descent_entry_reg   <= 32'd0;
            liftoff_flag_reg    <= 1'b0;
            tank_done_reg       <= 1'b0;
            burn_elapsed_reg    <= 32'd0;
            ascent_elapsed_reg  <= 32'd0;
            descent_elapsed_reg <= 32'd0;
        end
        else if (advance)
        begin
            phase_reg           <= phase_next;
            press_entry_reg     <= press_entry_next;
            liftoff_time_reg    <= liftoff_time_next;
            ascent_entry_reg    <= ascent_entry_next;
            descent_entry_reg   <= descent_entry_next;
            liftoff_flag_reg    <= liftoff_flag_next;
            tank_done_reg       <= tank_done_next;
            burn_elapsed_reg    <= burn_elapsed_next;
            ascent_elapsed_reg  <= ascent_elapsed_next;
            descent_elapsed_reg <= descent_elapsed_next;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_phase_reg   <= phase_next;
            res_changed_reg <= changed;
            res_ignite_reg  <= changed && (phase_next == PH_IGNITION);
            res_abort_reg   <= changed && ((phase_next == PH_ABORT_GND)
                                         || (phase_next == PH_ABORT_FLT));
            res_poff_reg    <= enter_ascent;
            res_epass_reg   <= enter_descent;
            res_tpass_reg   <= tpass;
            res_lift_reg    <= enter_burn;
            res_lifted_reg  <= liftoff_flag_next;
            res_ftime_reg   <= ftime;
        end
    end

    assign phase                  = res_phase_reg;
    assign phase_changed          = res_changed_reg;
    assign ignite_pulse           = res_ignite_reg;
    assign abort_pulse            = res_abort_reg;
    assign pressurize_off_pulse   = res_poff_reg;
    assign engine_passivate_pulse = res_epass_reg;
    assign tank_passivate_pulse   = res_tpass_reg;
    assign liftoff_pulse          = res_lift_reg;
    assign lifted_off             = res_lifted_reg;
    assign flight_time_ms         = res_ftime_reg;

endmodule
